FILE: rtl/address_range_table_top_defines.svh
// ----------------------------------------------------------------------------
// address range table assertion macros
// shared concurrent assertion helpers, clocked by clk and reset by rst_n
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_TABLE_TOP_DEFINES_SVH
`define ADDRESS_RANGE_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define ARNG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arng assertion failed");

// next-cycle implication
`define ARNG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arng assertion failed");

`endif

FILE: rtl/arng_pkg.sv
// ----------------------------------------------------------------------------
// arng_pkg
// shared widths, command codes and structs of the address range table
// ----------------------------------------------------------------------------
package arng_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 64;
    localparam int ROUTE_W  = 16;
    localparam int HANDLE_W = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // one stored range
    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   length;
        logic [ROUTE_W-1:0]  route;
        logic [HANDLE_W-1:0] handle;
    } arng_entry_t;

    localparam int ENTRY_W = $bits(arng_entry_t);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic clear_wr;
        logic commit;
    } arng_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } arng_sts_t;

endpackage

FILE: rtl/arng_req_if.sv
// ----------------------------------------------------------------------------
// arng_req_if
// request channel of the address range table
// ----------------------------------------------------------------------------
interface arng_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [63:0]        address;
    logic [63:0]        range_size;
    logic signed [15:0] route;
    logic [63:0]        owner_handle;

    modport source (
        output valid, command, address, range_size, route, owner_handle,
        input  ready
    );

    modport sink (
        input  valid, command, address, range_size, route, owner_handle,
        output ready
    );
endinterface

FILE: rtl/arng_rsp_if.sv
// ----------------------------------------------------------------------------
// arng_rsp_if
// response channel of the address range table
// ----------------------------------------------------------------------------
interface arng_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [63:0]        found_base;
    logic [63:0]        found_size;
    logic signed [15:0] found_route;
    logic [63:0]        found_handle;
    logic               status;

    modport source (
        output valid, hit, found_base, found_size, found_route, found_handle, status,
        input  ready
    );

    modport sink (
        input  valid, hit, found_base, found_size, found_route, found_handle, status,
        output ready
    );
endinterface

FILE: rtl/arng_ram.sv
// ----------------------------------------------------------------------------
// arng_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module arng_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/arng_dp.sv
// ----------------------------------------------------------------------------
// arng_dp
// table storage, scan pipeline, match and free-slot tracking, response register
// ----------------------------------------------------------------------------
module arng_dp #(
    parameter int TABLE_ENTRIES = arng_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  arng_pkg::arng_cmd_t              cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] idx,
    output arng_pkg::arng_sts_t              sts,
    input  logic [1:0]                       command,
    input  logic [63:0]                      address,
    input  logic [63:0]                      range_size,
    input  logic signed [15:0]               route,
    input  logic [63:0]                      owner_handle,
    output logic                             hit,
    output logic [63:0]                      found_base,
    output logic [63:0]                      found_size,
    output logic signed [15:0]               found_route,
    output logic [63:0]                      found_handle,
    output logic                             status
);

    import arng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // captured request
    logic [CMD_W-1:0]    req_cmd_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    logic [ADDR_W-1:0]   req_size_reg;
    logic [ROUTE_W-1:0]  req_route_reg;
    logic [HANDLE_W-1:0] req_handle_reg;

    // ram ports
    logic               vld_we;
    logic [IDX_W-1:0]   vld_waddr;
    logic [0:0]         vld_wdata;
    logic [0:0]         vld_rdata;
    logic [ENTRY_W-1:0] ent_rdata;
    logic               store;
    arng_entry_t        new_ent;

    // scan stage 1: ram data
    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    arng_entry_t        s1_ent;
    logic               s1_valid;
    logic               s1_eq;
    logic               s1_borrow;
    logic [ADDR_W-1:0]  s1_diff;
    logic               rm_we;
    logic               is_modify;
    logic               ins_ok;

    // scan stage 2: containment and best pick
    logic               s2_vld_reg;
    logic               s2_ge_reg;
    logic [ADDR_W-1:0]  s2_diff_reg;
    arng_entry_t        s2_ent_reg;
    logic               s2_better;

    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               best_found_reg;
    arng_entry_t        best_ent_reg;

    // response register
    logic               hit_reg;
    logic               status_reg;
    arng_entry_t        out_ent_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_cmd_reg    <= command;
            req_addr_reg   <= address;
            req_size_reg   <= range_size;
            req_route_reg  <= route;
            req_handle_reg <= owner_handle;
        end
    end

    assign is_modify = (req_cmd_reg == CMD_INSERT) || (req_cmd_reg == CMD_ERASE);
    assign ins_ok    = (req_cmd_reg == CMD_INSERT) && (req_addr_reg != '0)
                       && (req_size_reg != '0);
    assign store     = cmd.commit && ins_ok && free_found_reg;

    assign new_ent.base   = req_addr_reg;
    assign new_ent.length = req_size_reg;
    assign new_ent.route  = req_route_reg;
    assign new_ent.handle = req_handle_reg;

    // stage 1 compare: exact base match and base <= addr via borrow
    assign s1_ent   = arng_entry_t'(ent_rdata);
    assign s1_valid = vld_rdata[0];
    assign s1_eq    = s1_valid && (s1_ent.base == req_addr_reg);
    assign {s1_borrow, s1_diff} = {1'b0, req_addr_reg} - {1'b0, s1_ent.base};
    assign rm_we    = s1_vld_reg && s1_eq && is_modify;

    // valid ram write: clearing pass, removal during scan, store at commit
    always_comb
    begin
        vld_we    = 1'b0;
        vld_waddr = idx;
        vld_wdata = 1'b0;
        if (store)
        begin
            vld_we    = 1'b1;
            vld_waddr = free_idx_reg;
            vld_wdata = 1'b1;
        end
        else if (cmd.clear_wr)
        begin
            vld_we    = 1'b1;
            vld_waddr = idx;
        end
        else if (rm_we)
        begin
            vld_we    = 1'b1;
            vld_waddr = s1_idx_reg;
        end
    end

    arng_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_ENTRIES)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .raddr (idx),
        .rdata (vld_rdata)
    );

    arng_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (store),
        .waddr (free_idx_reg),
        .wdata (new_ent),
        .raddr (idx),
        .rdata (ent_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.rd_en;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.load)
            begin
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (s1_vld_reg && !free_found_reg && (!s1_valid || s1_eq))
                begin
                    free_found_reg <= 1'b1;
                end
                if (s2_better)
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    // lowest entry that is free once the same-base entry is gone
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg && !free_found_reg && (!s1_valid || s1_eq))
        begin
            free_idx_reg <= s1_idx_reg;
        end
        if (cmd.rd_en)
        begin
            s1_idx_reg <= idx;
        end
        s2_ge_reg   <= s1_valid && !s1_borrow;
        s2_diff_reg <= s1_diff;
        s2_ent_reg  <= s1_ent;
    end

    // greatest containing base wins, earlier entry keeps ties
    assign s2_better = s2_vld_reg && s2_ge_reg && (s2_diff_reg < s2_ent_reg.length)
                       && (!best_found_reg || (s2_ent_reg.base > best_ent_reg.base));

    always_ff @(posedge clk)
    begin
        if (s2_better)
        begin
            best_ent_reg <= s2_ent_reg;
        end
        if (cmd.commit)
        begin
            hit_reg    <= (req_cmd_reg == CMD_LOOKUP) && best_found_reg;
            status_reg <= ins_ok && !free_found_reg;
            if ((req_cmd_reg == CMD_LOOKUP) && best_found_reg)
            begin
                out_ent_reg <= best_ent_reg;
            end
            else
            begin
                out_ent_reg <= '0;
            end
        end
    end

    assign sts.pipe_busy = s1_vld_reg | s2_vld_reg;

    assign hit          = hit_reg;
    assign status       = status_reg;
    assign found_base   = out_ent_reg.base;
    assign found_size   = out_ent_reg.length;
    assign found_route  = $signed(out_ent_reg.route);
    assign found_handle = out_ent_reg.handle;

endmodule

FILE: rtl/arng_ctrl.sv
// ----------------------------------------------------------------------------
// arng_ctrl
// sequencer: clearing pass, table scan, pipeline drain, commit and handshakes
// ----------------------------------------------------------------------------
module arng_ctrl #(
    parameter int TABLE_ENTRIES = arng_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output arng_pkg::arng_cmd_t              cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] idx,
    input  arng_pkg::arng_sts_t              sts
);

    import arng_pkg::*;

    `include "address_range_table_top_defines.svh"

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign idx       = idx_reg;

    `ARNG_ASSERT_IMP(a_commit_slot_free, cmd.commit, !rsp_valid_reg || rsp_ready)
    `ARNG_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_reg)
    `ARNG_ASSERT_IMP(a_idle_pipe_empty, state_reg == ST_IDLE, !sts.pipe_busy)
    `ARNG_ASSERT_IMP(a_commit_after_drain, cmd.commit, !sts.pipe_busy)
    `ARNG_ASSERT_NEXT(a_scan_starts_at_zero, cmd.load, idx_reg == '0)

endmodule

FILE: rtl/address_range_table_top.sv
// ----------------------------------------------------------------------------
// address_range_table_top
// table of address ranges with insert, erase and greatest-base lookup
// ----------------------------------------------------------------------------
// usage
//   req: one request per handshake (valid and ready high at a clock edge):
//     insert (drops any range with the same base, then stores unless base or
//     size is zero or no entry is free), erase by base, or lookup of an address
//   rsp: exactly one response per request, in order
//   every request scans all TABLE_ENTRIES entries through the single read
//   port of each table ram, then drains a two stage compare pipeline and
//   commits; one request is in flight at a time, and the next is taken
//   the cycle after the commit
//   the response register frees req from rsp: a new request is taken while
//   an earlier response still waits; a stalled rsp holds its payload, and
//   a finished scan waits in commit until the response register frees up
//   reset: the valid bits are cleared by a pass over all TABLE_ENTRIES
//   entries, during which req.ready stays low; range data ram is not cleared
// ----------------------------------------------------------------------------
module address_range_table_top #(
    parameter int TABLE_ENTRIES = arng_pkg::TABLE_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    arng_req_if.sink  req,
    arng_rsp_if.source rsp
);

    import arng_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // command and status between sequencer and datapath
    arng_cmd_t        cmd;
    arng_sts_t        sts;
    logic [IDX_W-1:0] idx;

    // sequencer: owns handshakes and scan index
    arng_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .idx       (idx),
        .sts       (sts)
    );

    // datapath: table rams, compare pipeline, response payload
    arng_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .sts          (sts),
        .command      (req.command),
        .address      (req.address),
        .range_size   (req.range_size),
        .route        (req.route),
        .owner_handle (req.owner_handle),
        .hit          (rsp.hit),
        .found_base   (rsp.found_base),
        .found_size   (rsp.found_size),
        .found_route  (rsp.found_route),
        .found_handle (rsp.found_handle),
        .status       (rsp.status)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the address range table: directed and random
// insert, erase and lookup requests go in through req; a software copy of
// the table predicts every response, and each response from rsp is checked
// field by field, in order, against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import arng_pkg::*;

    localparam int          N_ENTRIES     = TABLE_ENTRIES_DEF;
    // no operation in the table; the block still answers with an all zero response
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    // backlog size the stimulus fills up to, at least
    localparam int          REQUEST_TOTAL = 1450;
    // idling stops once the backlog drops below this
    localparam int          CALM_TAIL     = 150;
    // watchdog bound: a full table scan per request, plus the gap and the stall
    // bursts of both sides; the worst case is taken over four times
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   range_size;
        logic [ROUTE_W-1:0]  route;
        logic [HANDLE_W-1:0] owner_handle;
    } range_request_t;

    typedef struct packed {
        logic                hit;
        logic [ADDR_W-1:0]   found_base;
        logic [ADDR_W-1:0]   found_size;
        logic [ROUTE_W-1:0]  found_route;
        logic [HANDLE_W-1:0] found_handle;
        logic                status;
    } range_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    arng_req_if req ();
    arng_rsp_if rsp ();

    address_range_table_top #(
        .TABLE_ENTRIES(N_ENTRIES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------
    // shadow copy of the range table, updated in request order
    // ------------------------------------------------------------------
    logic                tbl_valid  [N_ENTRIES];
    logic [ADDR_W-1:0]   tbl_base   [N_ENTRIES];
    logic [ADDR_W-1:0]   tbl_len    [N_ENTRIES];
    logic [ROUTE_W-1:0]  tbl_route  [N_ENTRIES];
    logic [HANDLE_W-1:0] tbl_handle [N_ENTRIES];

    range_request_t request_backlog  [$];
    range_reply_t   expected_replies [$];

    range_request_t driving_item;
    int             gap_left       = 0;
    int             stall_left     = 0;
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    logic           tail_calm      = 1'b0;

    // drop every stored range with this exact base
    function automatic void drop_base(logic [ADDR_W-1:0] base);
        for (int i = 0; i < N_ENTRIES; i++)
            if (tbl_valid[i] && tbl_base[i] == base)
                tbl_valid[i] = 1'b0;
    endfunction

    // apply one request to the shadow table and return the response it earns
    function automatic range_reply_t predict_table_op(range_request_t r);
        range_reply_t rep;
        int           best;
        rep  = '0;
        best = -1;
        case (r.command)
            CMD_INSERT:
            begin
                drop_base(r.address);
                // zero base or zero size: removal only, nothing stored
                if (r.address != '0 && r.range_size != '0)
                begin
                    rep.status = 1'b1;  // stays set if no free entry turns up
                    for (int i = 0; i < N_ENTRIES; i++)
                    begin
                        if (!tbl_valid[i])
                        begin
                            tbl_valid[i]  = 1'b1;
                            tbl_base[i]   = r.address;
                            tbl_len[i]    = r.range_size;
                            tbl_route[i]  = r.route;
                            tbl_handle[i] = r.owner_handle;
                            rep.status    = 1'b0;
                            break;
                        end
                    end
                end
            end
            CMD_ERASE: drop_base(r.address);
            CMD_LOOKUP:
            begin
                // containment without wrap: base <= addr and addr - base < size
                for (int i = 0; i < N_ENTRIES; i++)
                    if (tbl_valid[i] && tbl_base[i] <= r.address &&
                        (r.address - tbl_base[i]) < tbl_len[i])
                        if (best < 0 || tbl_base[i] > tbl_base[best])
                            best = i;
                if (best >= 0)
                begin
                    rep.hit          = 1'b1;
                    rep.found_base   = tbl_base[best];
                    rep.found_size   = tbl_len[best];
                    rep.found_route  = tbl_route[best];
                    rep.found_handle = tbl_handle[best];
                end
            end
            default: ;  // unused command: all zero response
        endcase
        return rep;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_request(logic [1:0] cmd, logic [63:0] addr,
                                          logic [63:0] size, logic [15:0] route,
                                          logic [63:0] handle);
        range_request_t r;
        r.command      = cmd;
        r.address      = addr;
        r.range_size   = size;
        r.route        = route;
        r.owner_handle = handle;
        request_backlog.push_back(r);
    endfunction

    // one random phase: a pool of 40 clustered bases (more than the table
    // holds, so it fills up and drops inserts), overlapping ranges, lookups
    // aimed mostly into the pool, some noise, and sometimes a full teardown
    task automatic build_random_phase(int n_ops);
        logic [63:0] pool [40];
        logic [63:0] region;
        logic [63:0] b;
        logic [63:0] sz;
        int unsigned stride;
        int unsigned sel;
        int unsigned pick;
        case ($urandom_range(0, 3))
            0:       region = ALL_ONES - 64'($urandom_range(0, 200000));  // top of space
            1:       region = 64'($urandom_range(0, 1 << 20));
            default: region = rand64();
        endcase
        stride = $urandom_range(1, 4096);
        for (int k = 0; k < 40; k++)
            pool[k] = region + 64'(k) * 64'(stride);
        repeat (n_ops)
        begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            b    = pool[$urandom_range(0, 39)];
            if (sel < 45)
            begin
                if (pick < 7)
                    sz = 64'($urandom_range(1, 6 * stride));
                else if (pick == 7)
                    sz = ALL_ONES;
                else if (pick == 8)
                    sz = rand64();
                else
                    sz = 64'd1;
                queue_request(CMD_INSERT, b, sz, 16'($urandom_range(0, 65535)), rand64());
            end
            else if (sel < 60)
            begin
                queue_request(CMD_ERASE, b, rand64(), 16'($urandom), rand64());
            end
            else if (sel < 93)
            begin
                if (pick < 7)
                    b = b + 64'($urandom_range(0, 6 * stride));
                else if (pick < 9)
                    b = b - 64'd1;
                else
                    b = rand64();
                queue_request(CMD_LOOKUP, b, rand64(), 16'($urandom), rand64());
            end
            else
            begin
                // noise: unused command, zero base, zero size, stray erase
                case (pick % 4)
                    0: queue_request(CMD_UNUSED, rand64(), rand64(), 16'($urandom), rand64());
                    1: queue_request(CMD_INSERT, '0, rand64(), 16'($urandom), rand64());
                    2: queue_request(CMD_INSERT, b, '0, 16'($urandom), rand64());
                    default: queue_request(CMD_ERASE, rand64(), '0, '0, '0);
                endcase
            end
        end
        if ($urandom_range(0, 1))
            for (int k = 0; k < 40; k++)
                queue_request(CMD_ERASE, pool[k], '0, '0, '0);
    endtask

    // ------------------------------------------------------------------
    // request driver: presents the backlog on req, one request at a time,
    // with random gap bursts; each accepted request is run through the
    // shadow table right away and its response queued for the checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_replies.push_back(predict_table_op(driving_item));
            tail_calm <= (request_backlog.size() < CALM_TAIL);
            if (req.valid && !req.ready)
            begin
                // hold the request until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req.valid <= 1'b0;
            end
            else if (request_backlog.size() == 0)
            begin
                req.valid <= 1'b0;
            end
            else if (!tail_calm && $urandom_range(0, 5) == 0)
            begin
                gap_left  = $urandom_range(0, 7);   // start a random idle burst
                req.valid <= 1'b0;
            end
            else
            begin
                driving_item      = request_backlog.pop_front();
                req.valid        <= 1'b1;
                req.command      <= driving_item.command;
                req.address      <= driving_item.address;
                req.range_size   <= driving_item.range_size;
                req.route        <= driving_item.route;
                req.owner_handle <= driving_item.owner_handle;
            end
        end
    end

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch on %s: expected %h actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // response monitor: random stall bursts on rsp.ready, every accepted
    // response checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        range_reply_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t response with no request pending: hit %b base %h status %b",
                             $time, rsp.hit, rsp.found_base, rsp.status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("hit",          64'(want.hit),          64'(rsp.hit));
                    check_field("found_base",   want.found_base,        rsp.found_base);
                    check_field("found_size",   want.found_size,        rsp.found_size);
                    // route compared as raw bits, no sign extension on either side
                    check_field("found_route",  64'(want.found_route),
                                64'($unsigned(rsp.found_route)));
                    check_field("found_handle", want.found_handle,      rsp.found_handle);
                    check_field("status",       64'(want.status),       64'(rsp.status));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (!tail_calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        // known values on every input from time zero
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.command      = '0;
        req.address      = '0;
        req.range_size   = '0;
        req.route        = '0;
        req.owner_handle = '0;
        rsp.ready        = 1'b0;
        for (int i = 0; i < N_ENTRIES; i++)
            tbl_valid[i] = 1'b0;

        // directed part
        queue_request(CMD_LOOKUP, '0, '0, '0, '0);                  // empty table miss
        queue_request(CMD_INSERT, '0, 64'd100, 16'd7, 64'd1);       // zero base: nothing stored
        queue_request(CMD_INSERT, 64'h1000, '0, 16'd7, 64'd1);      // zero size: erase only
        queue_request(CMD_INSERT, 64'h1000, 64'h100, 16'h8000, ALL_ONES);
        queue_request(CMD_INSERT, 64'h1080, 64'h10, 16'h7FFF, '0);  // nested range
        queue_request(CMD_LOOKUP, 64'h1000, '0, '0, '0);            // outer only
        queue_request(CMD_LOOKUP, 64'h1085, '0, '0, '0);            // greatest base wins
        queue_request(CMD_LOOKUP, 64'h108F, '0, '0, '0);            // last byte of inner
        queue_request(CMD_LOOKUP, 64'h1090, '0, '0, '0);            // just past inner
        queue_request(CMD_LOOKUP, 64'h10FF, '0, '0, '0);            // last byte of outer
        queue_request(CMD_LOOKUP, 64'h1100, '0, '0, '0);            // just past outer
        queue_request(CMD_LOOKUP, 64'h0FFF, '0, '0, '0);            // just below outer
        queue_request(CMD_INSERT, 64'h1080, 64'h40, 16'd5, 64'hABCD);  // same base replaces
        queue_request(CMD_LOOKUP, 64'h10B0, '0, '0, '0);
        // range at the top of the address space must not wrap
        queue_request(CMD_INSERT, ALL_ONES - 64'hFF, ALL_ONES, 16'hFFFF, rand64());
        queue_request(CMD_LOOKUP, ALL_ONES, '0, '0, '0);
        queue_request(CMD_LOOKUP, 64'd5, '0, '0, '0);
        queue_request(CMD_ERASE, 64'h2222, '0, '0, '0);             // absent base
        queue_request(CMD_ERASE, 64'h1080, '0, '0, '0);
        queue_request(CMD_LOOKUP, 64'h1085, '0, '0, '0);            // falls back to outer
        queue_request(CMD_INSERT, 64'h1000, '0, '0, '0);            // removes outer
        queue_request(CMD_LOOKUP, 64'h1000, '0, '0, '0);
        queue_request(CMD_UNUSED, ALL_ONES, ALL_ONES, 16'hFFFF, ALL_ONES);
        queue_request(CMD_INSERT, 64'd1, 64'd1, 16'd1, 64'd1);
        queue_request(CMD_LOOKUP, 64'd1, '0, '0, '0);
        queue_request(CMD_LOOKUP, 64'd2, '0, '0, '0);

        // random part, phase by phase
        while (request_backlog.size() < REQUEST_TOTAL)
            build_random_phase($urandom_range(60, 160));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sample at the falling edge so the driver and monitor have settled
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req.valid || expected_replies.size() != 0);

        // room for any stray response
        repeat (64) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/arng_pkg.sv
rtl/arng_req_if.sv
rtl/arng_rsp_if.sv
rtl/arng_ram.sv
rtl/arng_dp.sv
rtl/arng_ctrl.sv
rtl/address_range_table_top.sv
tb/tb_top.sv
